@@ design/bhq_pkg.sv @@
// ----------------------------------------------------------------------------
// bhq_pkg
// Shared types, field widths and operation codes for the binary min-heap
// priority queue.
// ----------------------------------------------------------------------------
package bhq_pkg;

  localparam int KEY_BITS     = 30;
  localparam int PAY_BITS     = 32;
  localparam int KIND_BITS    = 2;
  localparam int ERR_BITS     = 2;
  localparam int CAPACITY_DEF = 1024;

  // Input beat: key and payload, padded to whole bytes
  localparam int IN_W = ((KEY_BITS + PAY_BITS + 7) / 8) * 8;

  localparam logic [KIND_BITS-1:0] KIND_PUSH  = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_POP   = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_CLEAR = 2'd2;

  localparam logic [ERR_BITS-1:0] ERR_NONE  = 2'd0;
  localparam logic [ERR_BITS-1:0] ERR_FULL  = 2'd1;
  localparam logic [ERR_BITS-1:0] ERR_EMPTY = 2'd2;

  typedef struct packed {
    logic [PAY_BITS-1:0] pay;
    logic [KEY_BITS-1:0] key;
  } entry_t;

endpackage

@@ design/bhq_store.sv @@
// ----------------------------------------------------------------------------
// bhq_store
// Entry store of the heap: one write port and two registered read ports.
// ----------------------------------------------------------------------------
module bhq_store #(
  parameter int DEPTH = bhq_pkg::CAPACITY_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  bhq_pkg::entry_t wdata,
  input  logic [AW-1:0]   raddr0,
  input  logic [AW-1:0]   raddr1,
  output bhq_pkg::entry_t rdata0,
  output bhq_pkg::entry_t rdata1
);
  import bhq_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

@@ design/binary_min_heap_queue.sv @@
// ----------------------------------------------------------------------------
// binary_min_heap_queue
// Binary min-heap priority queue with a stream command port and a status port.
// ----------------------------------------------------------------------------
// Each input beat carries one command in s_tuser (push, pop minimum, clear)
// with the key and payload of a pushed entry in s_tdata. Every command yields
// exactly one status beat on the m_ side: root key and payload (zero when
// empty), entry count and empty flag in m_tdata, error code in m_tuser.
// A push on a full heap or a pop on an empty one leaves the heap unchanged.
//
// Entries live in a one-write, two-read store with registered reads; the
// sift loops move a hole one level per read step and compare-and-write-back
// step. A push goes start, then up and up-compare per level the entry rises
// (at most log2(CAPACITY) levels), then finish; a pop goes start, load of the
// last entry, then down and down-compare per level walked down, then finish,
// skipping the walk when it leaves the heap empty. Clear, an error or an
// unused command goes from start straight to finish. One command is in work
// at a time; the next one can be accepted in the cycle its status beat is
// raised.
//
// Reset empties the heap at once (the store is not swept). While a status
// beat waits on m_tready the next command is still accepted and worked; it
// holds in its final state until the status register frees up.
// ----------------------------------------------------------------------------
module binary_min_heap_queue #(
  parameter  int CAPACITY = bhq_pkg::CAPACITY_DEF,
  localparam int CNT_BITS = $clog2(CAPACITY + 1),
  localparam int OUT_W    = ((bhq_pkg::KEY_BITS + bhq_pkg::PAY_BITS + CNT_BITS + 1 + 7) / 8) * 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [bhq_pkg::IN_W-1:0]     s_tdata,  // key, payload
  input  logic [bhq_pkg::KIND_BITS-1:0] s_tuser, // kind
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [OUT_W-1:0]             m_tdata,  // top_key, top_payload, count, is_empty
  output logic [bhq_pkg::ERR_BITS-1:0] m_tuser   // error
);
  import bhq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam logic [CNT_BITS-1:0] CAP_CNT = CNT_BITS'(CAPACITY);
  localparam logic [CNT_BITS-1:0] ONE     = CNT_BITS'(1);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_START    = 3'd1;
  localparam logic [2:0] ST_POP_LOAD = 3'd2;
  localparam logic [2:0] ST_UP       = 3'd3;
  localparam logic [2:0] ST_UP_CMP   = 3'd4;
  localparam logic [2:0] ST_DOWN     = 3'd5;
  localparam logic [2:0] ST_DOWN_CMP = 3'd6;
  localparam logic [2:0] ST_FINISH   = 3'd7;

  logic [2:0]           state;
  logic [KIND_BITS-1:0] kind;
  entry_t               item;
  entry_t               cur;
  entry_t               root;
  logic [CNT_BITS-1:0]  cnt;
  logic [CNT_BITS-1:0]  p;
  logic [ERR_BITS-1:0]  err;

  entry_t               out_top;
  logic [CNT_BITS-1:0]  out_cnt;
  logic [ERR_BITS-1:0]  out_err;

  // store ports
  logic                 we;
  logic [AW-1:0]        waddr;
  entry_t               wdata;
  logic [AW-1:0]        raddr0;
  logic [AW-1:0]        raddr1;
  entry_t               rd0;
  entry_t               rd1;

  logic [CNT_BITS-1:0]  pm1;
  logic [CNT_BITS-1:0]  parent;
  logic [CNT_BITS-1:0]  parent_m1;
  logic [CNT_BITS-1:0]  cnt_m1;
  logic [CNT_BITS:0]    son;
  logic [CNT_BITS:0]    son_m1;
  logic [CNT_BITS:0]    cnt_ext;
  logic                 pick_right;
  entry_t               sel;
  logic [CNT_BITS:0]    sel_idx;
  logic                 out_free;

  assign pm1        = p - ONE;
  assign parent     = p >> 1;
  assign parent_m1  = parent - ONE;
  assign cnt_m1     = cnt - ONE;
  assign son        = {p, 1'b0};
  assign son_m1     = son - (CNT_BITS + 1)'(1);
  assign cnt_ext    = {1'b0, cnt};
  assign pick_right = (son < cnt_ext) && (rd0.key > rd1.key);
  assign sel        = pick_right ? rd1 : rd0;
  assign sel_idx    = pick_right ? son + (CNT_BITS + 1)'(1) : son;
  assign out_free   = !m_tvalid || m_tready;

  assign s_tready = (state == ST_IDLE);

  bhq_store #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr0 (raddr0),
    .raddr1 (raddr1),
    .rdata0 (rd0),
    .rdata1 (rd1)
  );

  // Store access per state; the hole holds cur until its final slot is found
  always_comb begin
    we     = 1'b0;
    waddr  = pm1[AW-1:0];
    wdata  = cur;
    raddr0 = '0;
    raddr1 = '0;
    case (state)
      ST_START: begin
        raddr0 = cnt_m1[AW-1:0];
      end
      ST_UP: begin
        if (p == ONE) begin
          we = 1'b1;
        end else begin
          raddr0 = parent_m1[AW-1:0];
        end
      end
      ST_UP_CMP: begin
        we    = 1'b1;
        wdata = (rd0.key > cur.key) ? rd0 : cur;
      end
      ST_DOWN: begin
        if (son > cnt_ext) begin
          we = 1'b1;
        end else begin
          raddr0 = son_m1[AW-1:0];
          raddr1 = son[AW-1:0];
        end
      end
      ST_DOWN_CMP: begin
        we    = 1'b1;
        wdata = (cur.key > sel.key) ? sel : cur;
      end
      default: begin
      end
    endcase
  end

  // Mirror of the root slot, so the status needs no extra read
  always_ff @(posedge clk) begin
    if (we && waddr == '0) begin
      root <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            kind  <= s_tuser;
            item  <= '{pay: s_tdata[KEY_BITS+PAY_BITS-1:KEY_BITS],
                       key: s_tdata[KEY_BITS-1:0]};
            err   <= ERR_NONE;
            state <= ST_START;
          end
        end
        ST_START: begin
          case (kind)
            KIND_PUSH: begin
              if (cnt >= CAP_CNT) begin
                err   <= ERR_FULL;
                state <= ST_FINISH;
              end else begin
                cnt   <= cnt + ONE;
                p     <= cnt + ONE;
                cur   <= item;
                state <= ST_UP;
              end
            end
            KIND_POP: begin
              if (cnt == '0) begin
                err   <= ERR_EMPTY;
                state <= ST_FINISH;
              end else begin
                cnt   <= cnt_m1;
                state <= ST_POP_LOAD;
              end
            end
            KIND_CLEAR: begin
              cnt   <= '0;
              state <= ST_FINISH;
            end
            default: begin
              state <= ST_FINISH;
            end
          endcase
        end
        ST_POP_LOAD: begin
          // last entry fills the root hole
          cur   <= rd0;
          p     <= ONE;
          state <= (cnt == '0) ? ST_FINISH : ST_DOWN;
        end
        ST_UP: begin
          state <= (p == ONE) ? ST_FINISH : ST_UP_CMP;
        end
        ST_UP_CMP: begin
          if (rd0.key > cur.key) begin
            p     <= parent;
            state <= ST_UP;
          end else begin
            state <= ST_FINISH;
          end
        end
        ST_DOWN: begin
          state <= (son > cnt_ext) ? ST_FINISH : ST_DOWN_CMP;
        end
        ST_DOWN_CMP: begin
          if (cur.key > sel.key) begin
            p     <= sel_idx[CNT_BITS-1:0];
            state <= ST_DOWN;
          end else begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Status register; hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      out_top <= (cnt != '0) ? root : '0;
      out_cnt <= cnt;
      out_err <= err;
    end
  end

  always_comb begin
    m_tdata = '0;
    m_tdata[KEY_BITS+PAY_BITS+CNT_BITS:0] =
      {(out_cnt == '0), out_cnt, out_top.pay, out_top.key};
  end

  assign m_tuser = out_err;

  a_cnt_bound : assert property (@(posedge clk) disable iff (rst)
    cnt <= CAP_CNT)
    else $error("entry count above capacity");

  a_full_count : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ERR_FULL) |->
      m_tdata[KEY_BITS+PAY_BITS+CNT_BITS-1:KEY_BITS+PAY_BITS] == CAP_CNT)
    else $error("full refusal reported with count below capacity");

  a_up_range : assert property (@(posedge clk) disable iff (rst)
    (state == ST_UP || state == ST_UP_CMP) |-> (p != '0 && p <= cnt))
    else $error("sift-up position outside the heap");

  a_result_src : assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_FINISH)
    else $error("status beat raised outside the finish step");

endmodule

@@ verif/binary_min_heap_queue_tb.sv @@
// ----------------------------------------------------------------------------
// binary_min_heap_queue_tb
// Self-checking bench for the binary min-heap priority queue.
// ----------------------------------------------------------------------------
// Commands come from a queue that the stimulus process fills. The first part
// is a directed sequence: extreme keys and payloads, equal keys, pop on
// empty, clear and the unused command. After it come random phases: a mixed
// phase, a fill past capacity to hit the full case, and a pop-heavy drain
// with no idling on either side. A shadow heap updates on every accepted
// command beat. Each status beat is checked field by field against the
// oldest expected status. Both sides idle at random. A watchdog ends the run
// when no beat moves for too long.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module binary_min_heap_queue_tb;
  import bhq_pkg::*;

  localparam int HEAP_DEPTH  = CAPACITY_DEF;
  localparam int CNT_W       = $clog2(CAPACITY_DEF + 1);
  localparam int OUT_W       = ((KEY_BITS + PAY_BITS + CNT_W + 1 + 7) / 8) * 8;
  localparam int STALL_LIMIT = 4000;
  localparam int IDLE_PCT    = 36;

  // unused command code; the block must treat it as a no-op
  localparam logic [KIND_BITS-1:0] KIND_NOP = 2'd3;

  typedef struct packed {
    logic [KIND_BITS-1:0] kind;
    logic [KEY_BITS-1:0]  key;
    logic [PAY_BITS-1:0]  pay;
  } heap_cmd_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] top_key;
    logic [PAY_BITS-1:0] top_pay;
    logic [CNT_W-1:0]    count;
    logic                empty;
    logic [ERR_BITS-1:0] err;
  } heap_status_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [IN_W-1:0]      s_tdata = '0;  // key, payload
  logic [KIND_BITS-1:0] s_tuser = '0;  // kind
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [OUT_W-1:0]     m_tdata;       // top_key, top_payload, count, is_empty
  logic [ERR_BITS-1:0]  m_tuser;       // error

  binary_min_heap_queue uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  heap_cmd_t    cmd_q[$];
  heap_status_t status_q[$];
  heap_cmd_t    next_cmd;
  heap_status_t want;
  heap_status_t got;

  logic                in_beat = 1'b0;
  logic                steady = 1'b0;
  int                  errors = 0;
  int                  stall_cycles = 0;
  int unsigned         gen_count = 0;

  // shadow heap, 1-based
  logic [KEY_BITS-1:0] heap_key [1:HEAP_DEPTH];
  logic [PAY_BITS-1:0] heap_pay [1:HEAP_DEPTH];
  int unsigned         shadow_count = 0;

  task automatic swap_slots(input int unsigned a, input int unsigned b);
    logic [KEY_BITS-1:0] k;
    logic [PAY_BITS-1:0] p;
    k = heap_key[a];
    p = heap_pay[a];
    heap_key[a] = heap_key[b];
    heap_pay[a] = heap_pay[b];
    heap_key[b] = k;
    heap_pay[b] = p;
  endtask

  task automatic apply_heap_op(input heap_cmd_t cmd, output heap_status_t st);
    int unsigned p;
    int unsigned son;
    st.err = ERR_NONE;
    case (cmd.kind)
      KIND_PUSH: begin
        if (shadow_count >= HEAP_DEPTH) begin
          st.err = ERR_FULL;
        end else begin
          shadow_count++;
          p = shadow_count;
          heap_key[p] = cmd.key;
          heap_pay[p] = cmd.pay;
          while (p > 1 && heap_key[p >> 1] > heap_key[p]) begin
            swap_slots(p >> 1, p);
            p = p >> 1;
          end
        end
      end
      KIND_POP: begin
        if (shadow_count == 0) begin
          st.err = ERR_EMPTY;
        end else begin
          heap_key[1] = heap_key[shadow_count];
          heap_pay[1] = heap_pay[shadow_count];
          shadow_count--;
          p = 1;
          while (2 * p <= shadow_count) begin
            son = 2 * p;
            if (son < shadow_count && heap_key[son] > heap_key[son + 1]) son++;
            if (!(heap_key[p] > heap_key[son])) break;
            swap_slots(p, son);
            p = son;
          end
        end
      end
      KIND_CLEAR: begin
        shadow_count = 0;
      end
      default: begin
      end
    endcase
    st.top_key = (shadow_count > 0) ? heap_key[1] : '0;
    st.top_pay = (shadow_count > 0) ? heap_pay[1] : '0;
    st.count   = shadow_count[CNT_W-1:0];
    st.empty   = (shadow_count == 0);
  endtask

  task automatic check_field(input string what, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, exp_v, act_v);
      errors++;
    end
  endtask

  // Monitor: predict on command beats, check status beats, watch for stalls.
  always @(posedge clk) begin
    if (rst) begin
      in_beat      <= 1'b0;
      stall_cycles <= 0;
    end else begin
      in_beat <= s_tvalid && s_tready;
      if (m_tvalid && m_tready) begin
        got.top_key = m_tdata[KEY_BITS-1:0];
        got.top_pay = m_tdata[KEY_BITS+PAY_BITS-1:KEY_BITS];
        got.count   = m_tdata[KEY_BITS+PAY_BITS+CNT_W-1:KEY_BITS+PAY_BITS];
        got.empty   = m_tdata[KEY_BITS+PAY_BITS+CNT_W];
        got.err     = m_tuser;
        if (status_q.size() == 0) begin
          $display("%0t ns: unexpected status beat, expected none, actual 0x%0h",
                   $time, got);
          errors++;
        end else begin
          want = status_q.pop_front();
          check_field("top_key", want.top_key, got.top_key);
          check_field("top_payload", want.top_pay, got.top_pay);
          check_field("count", want.count, got.count);
          check_field("is_empty", want.empty, got.empty);
          check_field("error", want.err, got.err);
        end
      end
      if (s_tvalid && s_tready) begin
        apply_heap_op('{kind: s_tuser, key: s_tdata[KEY_BITS-1:0],
                        pay: s_tdata[KEY_BITS+PAY_BITS-1:KEY_BITS]}, want);
        status_q.push_back(want);
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Driver: hold a command beat until accepted, then pull the next one.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
      if (!s_tvalid || in_beat) begin
        if (cmd_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          next_cmd = cmd_q.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= next_cmd.kind;
          s_tdata  <= {{(IN_W - KEY_BITS - PAY_BITS){1'b0}}, next_cmd.pay, next_cmd.key};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic add_cmd(input logic [KIND_BITS-1:0] kind, input logic [KEY_BITS-1:0] key,
                         input logic [PAY_BITS-1:0] pay);
    cmd_q.push_back('{kind: kind, key: key, pay: pay});
    case (kind)
      KIND_PUSH:  if (gen_count < HEAP_DEPTH) gen_count++;
      KIND_POP:   if (gen_count > 0) gen_count--;
      KIND_CLEAR: gen_count = 0;
      default: begin
      end
    endcase
  endtask

  // Bias toward a few small keys so equal keys meet often in the heap.
  function automatic logic [KEY_BITS-1:0] pick_key();
    int unsigned r;
    logic [31:0] raw;
    r   = $urandom_range(99);
    raw = $urandom;
    if (r < 25) return KEY_BITS'($urandom_range(15));
    if (r < 30) return '0;
    if (r < 35) return '1;
    return raw[KEY_BITS-1:0];
  endfunction

  task automatic add_random(input int unsigned push_pct, input int unsigned pop_pct);
    int unsigned r;
    logic [KIND_BITS-1:0] kind;
    r = $urandom_range(99);
    if (r < push_pct) kind = KIND_PUSH;
    else if (r < push_pct + pop_pct) kind = KIND_POP;
    else if (r[0]) kind = KIND_CLEAR;
    else kind = KIND_NOP;
    add_cmd(kind, pick_key(), $urandom);
  endtask

  // Hold off the sender until every expected status has come back.
  task automatic settle();
    while (cmd_q.size() != 0 || s_tvalid || status_q.size() != 0) @(negedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty-heap cases, extremes, equal keys, unused command
    add_cmd(KIND_POP, '1, '1);
    add_cmd(KIND_NOP, '0, '0);
    add_cmd(KIND_CLEAR, '1, '1);
    add_cmd(KIND_PUSH, '1, '1);
    add_cmd(KIND_PUSH, '0, '0);
    add_cmd(KIND_PUSH, '0, 32'h1234_5678);
    add_cmd(KIND_PUSH, 30'd5, 32'h0000_00a1);
    add_cmd(KIND_PUSH, 30'd5, 32'h0000_00b2);
    add_cmd(KIND_PUSH, 30'd3, 32'h8000_0001);
    add_cmd(KIND_NOP, 30'h2aaa_aaaa, 32'h5555_5555);
    add_cmd(KIND_PUSH, 30'h2aaa_aaaa, 32'h5555_5555);
    add_cmd(KIND_PUSH, 30'h1555_5555, 32'haaaa_aaaa);
    add_cmd(KIND_POP, '0, '0);
    add_cmd(KIND_POP, '0, '0);
    add_cmd(KIND_POP, '0, '0);
    add_cmd(KIND_POP, '0, '0);
    add_cmd(KIND_CLEAR, '0, '0);
    add_cmd(KIND_POP, '0, '0);
    add_cmd(KIND_PUSH, 30'd7, 32'hdead_beef);
    add_cmd(KIND_PUSH, 30'd7, 32'hcafe_f00d);
    add_cmd(KIND_POP, '0, '0);
    add_cmd(KIND_POP, '0, '0);
    add_cmd(KIND_POP, '0, '0);
    settle();

    // mixed traffic on a shallow heap
    repeat (350) add_random(50, 42);
    settle();

    // fill to capacity, then knock on the full heap
    if (gen_count > 0) add_cmd(KIND_CLEAR, pick_key(), $urandom);
    while (gen_count < HEAP_DEPTH) add_random(92, 8);
    repeat (6) add_cmd(KIND_PUSH, pick_key(), $urandom);
    add_cmd(KIND_POP, pick_key(), $urandom);
    add_cmd(KIND_PUSH, pick_key(), $urandom);
    add_cmd(KIND_PUSH, '0, '1);
    settle();

    // drain a deep heap with both sides running flat out
    steady = 1'b1;
    repeat (300) add_random(15, 83);
    settle();
    steady = 1'b0;

    add_cmd(KIND_CLEAR, pick_key(), $urandom);
    add_cmd(KIND_POP, pick_key(), $urandom);
    add_cmd(KIND_PUSH, '1, '0);
    add_cmd(KIND_POP, pick_key(), $urandom);
    settle();

    repeat (40) @(posedge clk);
    @(negedge clk);
    if (errors == 0 && status_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
